// ===== design/mpw_pkg.sv =====
// Shared types and constants for the mean pooling window core.
// Depends on nothing; every other design file but mpw_ram refers to it by scoped names.
package mpw_pkg;

  // Field and storage widths.
  localparam int unsigned SampleW  = 16;
  localparam int unsigned SumW     = 22;
  localparam int unsigned MaxCols  = 256;
  localparam int unsigned ColAddrW = 8;
  localparam int unsigned DivW     = 22;
  localparam int unsigned DenW     = 7;
  localparam int unsigned CntW     = 5;
  localparam int unsigned AddrW    = 5;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_WIN_W  = 3'd0,
    REG_WIN_H  = 3'd1,
    REG_IN_W   = 3'd2,
    REG_IN_H   = 3'd3,
    REG_MAPS   = 3'd4
  } reg_idx_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DCOL,
    ST_DROW,
    ST_RDREQ,
    ST_EVAL,
    ST_DSUM,
    ST_OUTW
  } state_e;

  // Divider operand selection.
  typedef enum logic [1:0] {
    DSEL_COL,
    DSEL_ROW,
    DSEL_SUM
  } div_sel_e;

  typedef struct packed {
    logic     accept;
    logic     div_start;
    div_sel_e div_sel;
    logic     lat_col;
    logic     lat_row;
    logic     ram_rd;
    logic     eval;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic win_end;
    logic out_free;
  } status_t;

endpackage

// ===== design/mpw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module mpw_ram #(
  parameter int unsigned WIDTH = 22,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/mpw_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on mpw_pkg for operand widths.
module mpw_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [mpw_pkg::DivW-1:0]   dividend_i,
  input  logic [mpw_pkg::DenW-1:0]   divisor_i,
  output logic [mpw_pkg::DivW-1:0]   quotient_o,
  output logic [mpw_pkg::DenW-1:0]   remainder_o,
  output logic                       done_o
);

  logic [mpw_pkg::DivW-1:0] quo_q, quo_d;
  logic [mpw_pkg::DenW-1:0] rem_q, rem_d, den_q;
  logic [mpw_pkg::CntW-1:0] cnt_q, cnt_d;
  logic                     done_q, done_d;
  logic [mpw_pkg::DenW:0]   rem_sh;
  logic [mpw_pkg::DenW:0]   rem_sub;
  logic                     ge;

  // One shift-and-subtract step.
  always_comb begin
    rem_sh  = {rem_q, quo_q[mpw_pkg::DivW-1]};
    ge      = rem_sh >= {1'b0, den_q};
    rem_sub = rem_sh - {1'b0, den_q};
    quo_d   = quo_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      cnt_d = mpw_pkg::CntW'(mpw_pkg::DivW);
    end else if (cnt_q != '0) begin
      quo_d  = {quo_q[mpw_pkg::DivW-2:0], ge};
      rem_d  = ge ? rem_sub[mpw_pkg::DenW-1:0] : rem_sh[mpw_pkg::DenW-1:0];
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == mpw_pkg::CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // Operand registers need no reset.
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= divisor_i;
    end
  end

  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;
  assign done_o      = done_q;

endmodule

// ===== design/mpw_ctrl.sv =====
// Controller state machine that sequences one item through the datapath.
// Depends on mpw_pkg for the state, command and status types.
module mpw_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  mpw_pkg::status_t status_i,
  output mpw_pkg::cmd_t    cmd_o
);

  mpw_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mpw_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mpw_pkg::ST_IDLE:  if (in_valid_i) state_d = mpw_pkg::ST_DCOL;
      mpw_pkg::ST_DCOL:  if (status_i.div_done) state_d = mpw_pkg::ST_DROW;
      mpw_pkg::ST_DROW:  if (status_i.div_done) state_d = mpw_pkg::ST_RDREQ;
      mpw_pkg::ST_RDREQ: state_d = mpw_pkg::ST_EVAL;
      mpw_pkg::ST_EVAL: begin
        state_d = status_i.win_end ? mpw_pkg::ST_DSUM : mpw_pkg::ST_IDLE;
      end
      mpw_pkg::ST_DSUM:  if (status_i.div_done) state_d = mpw_pkg::ST_OUTW;
      mpw_pkg::ST_OUTW:  if (status_i.out_free) state_d = mpw_pkg::ST_IDLE;
      default:           state_d = mpw_pkg::ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o         = '0;
    cmd_o.div_sel = mpw_pkg::DSEL_COL;
    in_stall_o    = 1'b1;
    unique case (state_q)
      mpw_pkg::ST_IDLE: begin
        in_stall_o      = 1'b0;
        cmd_o.accept    = in_valid_i;
        cmd_o.div_start = in_valid_i;
      end
      mpw_pkg::ST_DCOL: begin
        cmd_o.lat_col   = status_i.div_done;
        cmd_o.div_start = status_i.div_done;
        cmd_o.div_sel   = mpw_pkg::DSEL_ROW;
      end
      mpw_pkg::ST_DROW:  cmd_o.lat_row = status_i.div_done;
      mpw_pkg::ST_RDREQ: cmd_o.ram_rd = 1'b1;
      mpw_pkg::ST_EVAL: begin
        cmd_o.eval      = 1'b1;
        cmd_o.div_start = status_i.win_end;
        cmd_o.div_sel   = mpw_pkg::DSEL_SUM;
      end
      mpw_pkg::ST_DSUM:  ;
      mpw_pkg::ST_OUTW:  cmd_o.load_out = status_i.out_free;
      default:           ;
    endcase
  end

endmodule

// ===== design/mpw_datapath.sv =====
// Datapath: configuration registers, position counters, column sum buffer,
// shared divider and output register. Depends on mpw_pkg, mpw_ram, mpw_div.
module mpw_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mpw_pkg::cmd_t               cmd_i,
  output mpw_pkg::status_t            status_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mpw_pkg::AddrW-1:0]   paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  input  logic signed [15:0]          sample_i,
  input  logic                        out_stall_i,
  output logic                        out_valid_o,
  output logic signed [15:0]          mean_o,
  output logic [7:0]                  out_row_o,
  output logic [7:0]                  out_col_o,
  output logic [3:0]                  map_index_o,
  output logic                        last_o
);

  // Configuration registers.
  logic [3:0] win_w_q, win_h_q;
  logic [8:0] in_w_q, in_h_q;
  logic [4:0] maps_q;
  logic       wr_en;
  mpw_pkg::reg_idx_e reg_idx;

  assign reg_idx = mpw_pkg::reg_idx_e'(paddr[4:2]);
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_w_q <= 4'd2;
      win_h_q <= 4'd2;
      in_w_q  <= 9'd28;
      in_h_q  <= 9'd28;
      maps_q  <= 5'd1;
    end else if (wr_en) begin
      unique case (reg_idx)
        mpw_pkg::REG_WIN_W: win_w_q <= pwdata[3:0];
        mpw_pkg::REG_WIN_H: win_h_q <= pwdata[3:0];
        mpw_pkg::REG_IN_W:  in_w_q  <= pwdata[8:0];
        mpw_pkg::REG_IN_H:  in_h_q  <= pwdata[8:0];
        mpw_pkg::REG_MAPS:  maps_q  <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    unique case (reg_idx)
      mpw_pkg::REG_WIN_W: prdata = {28'd0, win_w_q};
      mpw_pkg::REG_WIN_H: prdata = {28'd0, win_h_q};
      mpw_pkg::REG_IN_W:  prdata = {23'd0, in_w_q};
      mpw_pkg::REG_IN_H:  prdata = {23'd0, in_h_q};
      mpw_pkg::REG_MAPS:  prdata = {27'd0, maps_q};
      default:            prdata = '0;
    endcase
  end

  // Effective sizes: zero acts as one, large values saturate.
  logic [3:0] ww, wh;
  logic [8:0] w, h;
  logic [4:0] mc;
  logic [6:0] area;

  always_comb begin
    ww = (win_w_q == '0) ? 4'd1 : ((win_w_q > 4'd8) ? 4'd8 : win_w_q);
    wh = (win_h_q == '0) ? 4'd1 : ((win_h_q > 4'd8) ? 4'd8 : win_h_q);
    w  = (in_w_q == '0) ? 9'd1 : ((in_w_q > 9'd256) ? 9'd256 : in_w_q);
    h  = (in_h_q == '0) ? 9'd1 : ((in_h_q > 9'd256) ? 9'd256 : in_h_q);
    mc = (maps_q == '0) ? 5'd1 : ((maps_q > 5'd16) ? 5'd16 : maps_q);
    area = 7'({3'd0, ww} * {3'd0, wh});
  end

  // Position state and per-item registers.
  logic [7:0]         in_col_q, in_row_q;
  logic [3:0]         map_q;
  logic signed [15:0] sample_q;
  logic [7:0]         ocol_q, orow_q;
  logic [6:0]         px_q, py_q;
  logic               sum_neg_q;
  logic [7:0]         res_row_q, res_col_q;
  logic [3:0]         res_map_q;
  logic               res_last_q;

  // Shared divider.
  logic [mpw_pkg::DivW-1:0] div_dividend, div_quo;
  logic [mpw_pkg::DenW-1:0] div_divisor, div_rem;
  logic                     div_done;

  // Column sum buffer.
  logic [mpw_pkg::SumW-1:0] ram_rdata;
  logic                     ram_we;

  // Window evaluation.
  logic signed [22:0] sum;
  logic [22:0]        sum_mag;
  logic [12:0]        col_lim, row_lim;
  logic [13:0]        col_nxt, row_nxt;
  logic               col_ok, row_ok, win_hit, col_last, row_last, is_last;

  always_comb begin
    if (px_q == '0 && py_q == '0) begin
      sum = 23'(sample_q);
    end else begin
      sum = 23'($signed(ram_rdata)) + 23'(sample_q);
    end
    sum_mag  = sum[22] ? 23'(-sum) : 23'(sum);
    col_lim  = 13'(({1'b0, ocol_q} + 9'd1) * {5'd0, ww});
    row_lim  = 13'(({1'b0, orow_q} + 9'd1) * {5'd0, wh});
    col_nxt  = 14'(({2'b0, ocol_q} + 10'd2) * {6'd0, ww});
    row_nxt  = 14'(({2'b0, orow_q} + 10'd2) * {6'd0, wh});
    col_ok   = col_lim <= {4'd0, w};
    row_ok   = row_lim <= {4'd0, h};
    col_last = col_nxt > {5'd0, w};
    row_last = row_nxt > {5'd0, h};
    win_hit  = (px_q == {3'd0, ww - 4'd1}) && (py_q == {3'd0, wh - 4'd1});
    is_last  = col_last && row_last && ({1'b0, map_q} == mc - 5'd1);
  end

  assign ram_we = cmd_i.eval & col_ok & row_ok & ~win_hit;

  // Divider operand selection.
  always_comb begin
    unique case (cmd_i.div_sel)
      mpw_pkg::DSEL_COL: begin
        div_dividend = {14'd0, in_col_q};
        div_divisor  = {3'd0, ww};
      end
      mpw_pkg::DSEL_ROW: begin
        div_dividend = {14'd0, in_row_q};
        div_divisor  = {3'd0, wh};
      end
      mpw_pkg::DSEL_SUM: begin
        div_dividend = sum_mag[mpw_pkg::DivW-1:0];
        div_divisor  = area;
      end
      default: begin
        div_dividend = '0;
        div_divisor  = 7'd1;
      end
    endcase
  end

  mpw_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .quotient_o  (div_quo),
    .remainder_o (div_rem),
    .done_o      (div_done)
  );

  mpw_ram #(
    .WIDTH (mpw_pkg::SumW),
    .DEPTH (mpw_pkg::MaxCols)
  ) u_sums (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ocol_q),
    .wdata_i (sum[mpw_pkg::SumW-1:0]),
    .re_i    (cmd_i.ram_rd),
    .raddr_i (ocol_q),
    .rdata_o (ram_rdata)
  );

  // Raster position advance after each item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q <= '0;
      in_row_q <= '0;
      map_q    <= '0;
    end else if (cmd_i.eval) begin
      if ({1'b0, in_col_q} + 9'd1 < w) begin
        in_col_q <= in_col_q + 8'd1;
      end else begin
        in_col_q <= '0;
        if ({1'b0, in_row_q} + 9'd1 < h) begin
          in_row_q <= in_row_q + 8'd1;
        end else begin
          in_row_q <= '0;
          map_q    <= ({1'b0, map_q} + 5'd1 < mc) ? map_q + 4'd1 : '0;
        end
      end
    end
  end

  // Per-item payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sample_q <= sample_i;
    end
    if (cmd_i.lat_col) begin
      ocol_q <= div_quo[7:0];
      px_q   <= div_rem;
    end
    if (cmd_i.lat_row) begin
      orow_q <= div_quo[7:0];
      py_q   <= div_rem;
    end
    if (cmd_i.eval) begin
      sum_neg_q  <= sum[22];
      res_row_q  <= orow_q;
      res_col_q  <= ocol_q;
      res_map_q  <= map_q;
      res_last_q <= is_last;
    end
  end

  // Output register.
  logic              out_valid_q;
  logic signed [15:0] mean_q;
  logic [7:0]        out_row_q, out_col_q;
  logic [3:0]        out_map_q;
  logic              out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      mean_q     <= sum_neg_q ? 16'(-div_quo[15:0]) : div_quo[15:0];
      out_row_q  <= res_row_q;
      out_col_q  <= res_col_q;
      out_map_q  <= res_map_q;
      out_last_q <= res_last_q;
    end
  end

  assign status_o.div_done = div_done;
  assign status_o.win_end  = col_ok & row_ok & win_hit;
  assign status_o.out_free = ~out_valid_q | ~out_stall_i;

  assign out_valid_o = out_valid_q;
  assign mean_o      = mean_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign map_index_o = out_map_q;
  assign last_o      = out_last_q;

endmodule

// ===== design/mean_pooling_window_core.sv =====
// Top level of the streaming 2-D mean pooling core.
// Depends on mpw_pkg, mpw_ctrl and mpw_datapath.
//
//   Channel   Direction  Handshake                  Payload
//   in        input      in_valid_i / in_stall_o    sample_i
//   out       output     out_valid_o / out_stall_i  mean_o, out_row_o, out_col_o,
//                                                   map_index_o, last_o
//   config    input      APB psel/penable/pready    paddr, pwdata, prdata
//
// Each item passes an idle step, the column and row positions on the shared
// bit-serial divider, a buffer read and evaluation; the input is stalled until
// the controller returns to idle. An item that closes a window adds a division
// for the mean and a load of the output register.
// Reset clears positions and loads register defaults; the column sum buffer
// is not cleared. While a stalled result sits in the output register, the next
// result waits in the last step and the input stays stalled.
module mean_pooling_window_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [mpw_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [15:0]        sample_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [15:0]        mean_o,
  output logic [7:0]                out_row_o,
  output logic [7:0]                out_col_o,
  output logic [3:0]                map_index_o,
  output logic                      last_o
);

  mpw_pkg::cmd_t    cmd;
  mpw_pkg::status_t status;

  assign pready = 1'b1;

  mpw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mpw_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .sample_i    (sample_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .mean_o      (mean_o),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .map_index_o (map_index_o),
    .last_o      (last_o)
  );

endmodule
